/* src/chbd_pkg.sv */
package chbd_pkg;

  // Width of the chunk size counter.
  localparam int COUNT_W = 32;
  // Width of the chunk size limit register.
  localparam int LIMIT_W = 31;
  // Width used when the counter is compared against the limit.
  localparam int CMP_W = (COUNT_W > LIMIT_W) ? COUNT_W : LIMIT_W;

  // Depth of the queue between the classifier and the parser.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  typedef enum logic [2:0] {
    PH_SIZE    = 3'd0,
    PH_EXT     = 3'd1,
    PH_SIZE_LF = 3'd2,
    PH_DATA    = 3'd3,
    PH_DATA_CR = 3'd4,
    PH_DATA_LF = 3'd5,
    PH_DONE    = 3'd6,
    PH_HALT    = 3'd7
  } phase_t;

  // A received byte together with its classification.
  typedef struct packed {
    logic [7:0] data;
    logic       start;
    logic       hex_ok;
    logic [3:0] hex_val;
    logic       is_cr;
    logic       is_lf;
  } item_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       payload_valid;
    logic       message_done;
    logic       format_error;
  } result_t;

endpackage

/* src/chbd_if.sv */
interface chbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       message_start;

  modport source (output valid, output in_byte, output message_start, input ready);
  modport sink (input valid, input in_byte, input message_start, output ready);
endinterface

interface chbd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       payload_valid;
  logic       message_done;
  logic       format_error;

  modport source (output valid, output payload_byte, output payload_valid,
                  output message_done, output format_error, input ready);
  modport sink (input valid, input payload_byte, input payload_valid,
                input message_done, input format_error, output ready);
endinterface

/* src/chbd_front.sv */
module chbd_front (
  chbd_in_if.sink         in_ch,
  input  logic            q_full,
  output logic            push,
  output chbd_pkg::item_t push_item
);

  logic [7:0] b;

  assign b           = in_ch.in_byte;
  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;

  // Decode the byte as a hexadecimal digit of either case, and flag CR and LF.
  always_comb begin
    push_item.data    = b;
    push_item.start   = in_ch.message_start;
    push_item.is_cr   = (b == chbd_pkg::CH_CR);
    push_item.is_lf   = (b == chbd_pkg::CH_LF);
    push_item.hex_ok  = 1'b0;
    push_item.hex_val = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      push_item.hex_ok  = 1'b1;
      push_item.hex_val = b[3:0];
    end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
      push_item.hex_ok  = 1'b1;
      push_item.hex_val = b[3:0] + 4'd9;
    end
  end

endmodule

/* src/chbd_queue.sv */
module chbd_queue (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  input  chbd_pkg::item_t          push_item,
  output logic                     full,
  input  logic                     pop,
  output chbd_pkg::item_t          pop_item,
  output logic                     not_empty
);

  chbd_pkg::item_t                     slot_r [chbd_pkg::QDEPTH];
  logic [chbd_pkg::QPTR_W-1:0]         wr_ptr_r, wr_ptr_nxt;
  logic [chbd_pkg::QPTR_W-1:0]         rd_ptr_r, rd_ptr_nxt;
  logic [chbd_pkg::QCNT_W-1:0]         count_r, count_nxt;

  assign full      = (count_r == chbd_pkg::QCNT_W'(chbd_pkg::QDEPTH));
  assign not_empty = (count_r != '0);
  assign pop_item  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == chbd_pkg::QPTR_W'(chbd_pkg::QDEPTH - 1)) ? '0
                   : wr_ptr_r + chbd_pkg::QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == chbd_pkg::QPTR_W'(chbd_pkg::QDEPTH - 1)) ? '0
                   : rd_ptr_r + chbd_pkg::QPTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + chbd_pkg::QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - chbd_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

/* src/chbd_back.sv */
module chbd_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [chbd_pkg::LIMIT_W-1:0]    max_size,
  input  logic                            q_valid,
  input  chbd_pkg::item_t                 it,
  output logic                            pop,
  chbd_out_if.source                      out_ch
);

  chbd_pkg::phase_t                 phase_r, phase_nxt, ph;
  logic [chbd_pkg::COUNT_W-1:0]     cnt_r, cnt_nxt, c, shifted, dec;
  logic                             digit_r, digit_nxt, d;
  logic                             err_r, err_nxt, e;
  logic                             ov_r, ov_nxt;
  chbd_pkg::result_t                res_r, res_nxt, res;

  assign pop = q_valid && (!ov_r || out_ch.ready);

  assign out_ch.valid         = ov_r;
  assign out_ch.payload_byte  = res_r.payload_byte;
  assign out_ch.payload_valid = res_r.payload_valid;
  assign out_ch.message_done  = res_r.message_done;
  assign out_ch.format_error  = res_r.format_error;

  // A message start clears the parser before the byte is looked at.
  assign ph      = it.start ? chbd_pkg::PH_SIZE : phase_r;
  assign c       = it.start ? '0 : cnt_r;
  assign d       = it.start ? 1'b0 : digit_r;
  assign e       = it.start ? 1'b0 : err_r;
  assign shifted = {c[chbd_pkg::COUNT_W-5:0], it.hex_val};
  assign dec     = c - chbd_pkg::COUNT_W'(1);

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    digit_nxt = digit_r;
    err_nxt   = err_r;
    res       = '0;
    if (pop) begin
      phase_nxt = ph;
      cnt_nxt   = c;
      digit_nxt = d;
      err_nxt   = e;
      case (ph)
        chbd_pkg::PH_SIZE: begin
          if (it.hex_ok) begin
            if (|c[chbd_pkg::COUNT_W-1:chbd_pkg::COUNT_W-4]) begin
              err_nxt   = 1'b1;
              phase_nxt = chbd_pkg::PH_HALT;
            end else begin
              cnt_nxt   = shifted;
              digit_nxt = 1'b1;
              if (chbd_pkg::CMP_W'(shifted) > chbd_pkg::CMP_W'(max_size)) begin
                err_nxt   = 1'b1;
                phase_nxt = chbd_pkg::PH_HALT;
              end
            end
          end else if (it.is_cr) begin
            phase_nxt = chbd_pkg::PH_SIZE_LF;
          end else if (it.is_lf) begin
            err_nxt   = 1'b1;
            phase_nxt = chbd_pkg::PH_HALT;
          end else begin
            phase_nxt = chbd_pkg::PH_EXT;
          end
        end
        chbd_pkg::PH_EXT: begin
          if (it.is_cr) begin
            phase_nxt = chbd_pkg::PH_SIZE_LF;
          end else if (it.is_lf) begin
            err_nxt   = 1'b1;
            phase_nxt = chbd_pkg::PH_HALT;
          end
        end
        chbd_pkg::PH_SIZE_LF: begin
          if (!it.is_lf || !d) begin
            err_nxt   = 1'b1;
            phase_nxt = chbd_pkg::PH_HALT;
          end else if (c == '0) begin
            res.message_done = 1'b1;
            phase_nxt        = chbd_pkg::PH_DONE;
          end else begin
            phase_nxt = chbd_pkg::PH_DATA;
          end
        end
        chbd_pkg::PH_DATA: begin
          res.payload_byte  = it.data;
          res.payload_valid = 1'b1;
          cnt_nxt           = dec;
          if (dec == '0) begin
            phase_nxt = chbd_pkg::PH_DATA_CR;
          end
        end
        chbd_pkg::PH_DATA_CR: begin
          if (it.is_cr) begin
            phase_nxt = chbd_pkg::PH_DATA_LF;
          end else begin
            err_nxt   = 1'b1;
            phase_nxt = chbd_pkg::PH_HALT;
          end
        end
        chbd_pkg::PH_DATA_LF: begin
          if (it.is_lf) begin
            phase_nxt = chbd_pkg::PH_SIZE;
            cnt_nxt   = '0;
            digit_nxt = 1'b0;
          end else begin
            err_nxt   = 1'b1;
            phase_nxt = chbd_pkg::PH_HALT;
          end
        end
        default: begin
        end
      endcase
      res.format_error = err_nxt;
    end
  end

  always_comb begin
    ov_nxt  = pop ? 1'b1 : (out_ch.ready ? 1'b0 : ov_r);
    res_nxt = pop ? res : res_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= chbd_pkg::PH_SIZE;
      cnt_r   <= '0;
      digit_r <= 1'b0;
      err_r   <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      digit_r <= digit_nxt;
      err_r   <= err_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

endmodule

/* src/http_chunked_body_decoder.sv */
// Channel  | Direction | Fields                                          | Handshake
// in_ch    | sink      | in_byte, message_start                          | valid/ready
// out_ch   | source    | payload_byte, payload_valid, message_done,      | valid/ready
//          |           | format_error                                    |
// cfg      | sink      | cfg_wdata (max_chunk_size)                      | cfg_we
//
// One byte is taken per clock cycle while in_ch.ready is high, and one result
// transaction leaves per byte; bytes pass a queue slot, then the output register.
// The size line, data and framing checks are handled by one state machine step
// per byte. Reset is synchronous and active low; it clears the parser state,
// the queue pointers and the output valid, and loads the size limit 0x7FFFFFFF.
// A stalled output first holds its result, then fills the queue, and only then
// drops in_ch.ready.

module http_chunked_body_decoder (
  input  logic                          clk,
  input  logic                          rst_n,
  chbd_in_if.sink                       in_ch,
  chbd_out_if.source                    out_ch,
  input  logic                          cfg_we,
  input  logic [chbd_pkg::LIMIT_W-1:0]  cfg_wdata
);

  // Largest chunk size accepted; a larger size line is a format error.
  logic [chbd_pkg::LIMIT_W-1:0] max_size_r, max_size_nxt;

  logic            push;
  logic            pop;
  logic            q_full;
  logic            q_valid;
  chbd_pkg::item_t push_item;
  chbd_pkg::item_t pop_item;

  assign max_size_nxt = cfg_we ? cfg_wdata : max_size_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_size_r <= {chbd_pkg::LIMIT_W{1'b1}};
    end else begin
      max_size_r <= max_size_nxt;
    end
  end

  // The front end accepts each input transaction and classifies the byte
  // (hexadecimal digit and its value, CR, LF) before it is queued.
  chbd_front u_front (
    .in_ch     (in_ch),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  // The queue decouples the front end from the parser, so that either side
  // can stall without stopping the other at once.
  chbd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .pop_item  (pop_item),
    .not_empty (q_valid)
  );

  // The back end walks the chunk framing one byte at a time and registers
  // exactly one result transaction per byte.
  chbd_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .max_size (max_size_r),
    .q_valid  (q_valid),
    .it       (pop_item),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule

/* tb/http_chunked_body_decoder_test.sv */
`timescale 1ns / 100ps

// Self-checking bench for the chunked body decoder. Raw body bytes go in as
// input transactions, and each one must give exactly one result transaction.
// A behavioural copy of the decoder runs alongside the block. It predicts every
// result at the moment its input transaction is accepted, and the prediction
// (or a hand-written result) waits in a queue until the matching result turns up.
module http_chunked_body_decoder_test;

  localparam int HALF_PERIOD = 4;
  // Extra wait of the drain after the last owed result has come back.
  localparam int SETTLE_CYCLES = 4;
  // Longest run of cycles without any transaction before we give up.
  localparam int QUIET_LIMIT = 2000;
  localparam int BYTES_PER_SETTING = 292;
  localparam logic [chbd_pkg::COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic { ROW_BYTE, ROW_LIMIT } row_kind_t;

  // One line of the directed script. A ROW_LIMIT line writes the size limit;
  // a ROW_BYTE line sends one byte. Where "typed" is set, "want" holds the
  // result written out by hand; otherwise the bench predicts it.
  typedef struct packed {
    row_kind_t                    kind;
    logic [chbd_pkg::LIMIT_W-1:0] limit;
    logic [7:0]                   data;
    logic                         start;
    logic                         typed;
    chbd_pkg::result_t            want;
  } script_row_t;

  localparam chbd_pkg::result_t NOTHING  = '0;
  localparam chbd_pkg::result_t FAILED   = '{8'h00, 1'b0, 1'b0, 1'b1};
  localparam chbd_pkg::result_t FINISHED = '{8'h00, 1'b0, 1'b1, 1'b0};
  localparam chbd_pkg::result_t DATA_FF  = '{8'hFF, 1'b1, 1'b0, 1'b0};

  // Directed opening: a complete message with an extension holding a hex
  // digit, one 0xFF data byte and the terminating zero-size line, a byte after
  // the end, a size line with no digits, a bare LF in a size line, an
  // accumulator overflow and, with the limit at zero, an oversize chunk.
  localparam script_row_t OPENING [29] = '{
    '{ROW_BYTE,  31'd0,         "1",             1'b1, 1'b1, NOTHING},
    '{ROW_BYTE,  31'd0,         ";",             1'b0, 1'b0, NOTHING},
    '{ROW_BYTE,  31'd0,         "f",             1'b0, 1'b0, NOTHING},
    '{ROW_BYTE,  31'd0,         chbd_pkg::CH_CR, 1'b0, 1'b0, NOTHING},
    '{ROW_BYTE,  31'd0,         chbd_pkg::CH_LF, 1'b0, 1'b0, NOTHING},
    '{ROW_BYTE,  31'd0,         8'hFF,           1'b0, 1'b1, DATA_FF},
    '{ROW_BYTE,  31'd0,         chbd_pkg::CH_CR, 1'b0, 1'b0, NOTHING},
    '{ROW_BYTE,  31'd0,         chbd_pkg::CH_LF, 1'b0, 1'b0, NOTHING},
    '{ROW_BYTE,  31'd0,         "0",             1'b0, 1'b0, NOTHING},
    '{ROW_BYTE,  31'd0,         chbd_pkg::CH_CR, 1'b0, 1'b0, NOTHING},
    '{ROW_BYTE,  31'd0,         chbd_pkg::CH_LF, 1'b0, 1'b1, FINISHED},
    '{ROW_BYTE,  31'd0,         8'h00,           1'b0, 1'b1, NOTHING},
    '{ROW_BYTE,  31'd0,         chbd_pkg::CH_CR, 1'b1, 1'b0, NOTHING},
    '{ROW_BYTE,  31'd0,         chbd_pkg::CH_LF, 1'b0, 1'b1, FAILED},
    '{ROW_BYTE,  31'd0,         "Z",             1'b0, 1'b1, FAILED},
    '{ROW_BYTE,  31'd0,         "F",             1'b1, 1'b0, NOTHING},
    '{ROW_BYTE,  31'd0,         chbd_pkg::CH_LF, 1'b0, 1'b1, FAILED},
    '{ROW_BYTE,  31'd0,         "1",             1'b1, 1'b0, NOTHING},
    '{ROW_BYTE,  31'd0,         "0",             1'b0, 1'b0, NOTHING},
    '{ROW_BYTE,  31'd0,         "0",             1'b0, 1'b0, NOTHING},
    '{ROW_BYTE,  31'd0,         "0",             1'b0, 1'b0, NOTHING},
    '{ROW_BYTE,  31'd0,         "0",             1'b0, 1'b0, NOTHING},
    '{ROW_BYTE,  31'd0,         "0",             1'b0, 1'b0, NOTHING},
    '{ROW_BYTE,  31'd0,         "0",             1'b0, 1'b0, NOTHING},
    '{ROW_BYTE,  31'd0,         "0",             1'b0, 1'b0, NOTHING},
    '{ROW_BYTE,  31'd0,         "0",             1'b0, 1'b1, FAILED},
    '{ROW_LIMIT, 31'd0,         8'h00,           1'b0, 1'b0, NOTHING},
    '{ROW_BYTE,  31'd0,         "1",             1'b1, 1'b1, FAILED},
    '{ROW_LIMIT, 31'h7FFF_FFFF, 8'h00,           1'b0, 1'b0, NOTHING}
  };

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [chbd_pkg::LIMIT_W-1:0] cfg_wdata;

  chbd_in_if  in_ch ();
  chbd_out_if out_ch ();

  http_chunked_body_decoder i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Results still owed by the block, oldest first.
  chbd_pkg::result_t awaited_results [$];
  // Bytes of the message currently being sent.
  logic [7:0] frame_q [$];

  int  mismatches = 0;
  int  results_seen = 0;
  // When set, neither side inserts random gaps.
  bit  calm = 1'b0;
  // Set by the stimulus to make the result side refuse for this many cycles.
  int  hold_request = 0;

  // Behavioural copy of the decoder state.
  logic [chbd_pkg::LIMIT_W-1:0] size_limit;
  chbd_pkg::phase_t             phase;
  logic [chbd_pkg::COUNT_W-1:0] remaining;
  logic                         got_digit;
  logic                         sticky_fail;

  initial clk = 1'b0;
  always #HALF_PERIOD clk = ~clk;

  // ---------------------------------------------------------------------------
  // Prediction.
  // ---------------------------------------------------------------------------

  function automatic void clear_parser();
    phase       = chbd_pkg::PH_SIZE;
    remaining   = '0;
    got_digit   = 1'b0;
    sticky_fail = 1'b0;
  endfunction

  function automatic void halt_parser();
    sticky_fail = 1'b1;
    phase       = chbd_pkg::PH_HALT;
  endfunction

  // Steps the decoder copy by one byte and returns the result it gives.
  function automatic chbd_pkg::result_t decode_byte(input logic [7:0] b, input logic start);
    chbd_pkg::result_t r;
    logic              is_hex;
    logic [3:0]        nib;
    r      = '0;
    is_hex = 1'b1;
    nib    = '0;
    if (start) begin
      clear_parser();
    end
    if (b >= "0" && b <= "9") begin
      nib = 4'(b - "0");
    end else if (b >= "a" && b <= "f") begin
      nib = 4'(b - "a" + 8'd10);
    end else if (b >= "A" && b <= "F") begin
      nib = 4'(b - "A" + 8'd10);
    end else begin
      is_hex = 1'b0;
    end
    case (phase)
      chbd_pkg::PH_SIZE: begin
        if (is_hex) begin
          // A digit that cannot be shifted in without losing the top nibble
          // overflows; otherwise the new size is checked against the limit.
          if (remaining > (COUNT_MAX >> 4)) begin
            halt_parser();
          end else begin
            remaining = {remaining[chbd_pkg::COUNT_W-5:0], nib};
            got_digit = 1'b1;
            if (remaining > chbd_pkg::COUNT_W'(size_limit)) begin
              halt_parser();
            end
          end
        end else if (b == chbd_pkg::CH_CR) begin
          phase = chbd_pkg::PH_SIZE_LF;
        end else if (b == chbd_pkg::CH_LF) begin
          halt_parser();
        end else begin
          phase = chbd_pkg::PH_EXT;
        end
      end
      chbd_pkg::PH_EXT: begin
        if (b == chbd_pkg::CH_CR) begin
          phase = chbd_pkg::PH_SIZE_LF;
        end else if (b == chbd_pkg::CH_LF) begin
          halt_parser();
        end
      end
      chbd_pkg::PH_SIZE_LF: begin
        if (b != chbd_pkg::CH_LF || !got_digit) begin
          halt_parser();
        end else if (remaining == '0) begin
          r.message_done = 1'b1;
          phase = chbd_pkg::PH_DONE;
        end else begin
          phase = chbd_pkg::PH_DATA;
        end
      end
      chbd_pkg::PH_DATA: begin
        r.payload_byte  = b;
        r.payload_valid = 1'b1;
        remaining = remaining - chbd_pkg::COUNT_W'(1);
        if (remaining == '0) begin
          phase = chbd_pkg::PH_DATA_CR;
        end
      end
      chbd_pkg::PH_DATA_CR: begin
        if (b == chbd_pkg::CH_CR) begin
          phase = chbd_pkg::PH_DATA_LF;
        end else begin
          halt_parser();
        end
      end
      chbd_pkg::PH_DATA_LF: begin
        if (b == chbd_pkg::CH_LF) begin
          phase     = chbd_pkg::PH_SIZE;
          remaining = '0;
          got_digit = 1'b0;
        end else begin
          halt_parser();
        end
      end
      default: begin
      end
    endcase
    r.format_error = sticky_fail;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Handshake helpers.
  // ---------------------------------------------------------------------------

  // Mostly back-to-back, sometimes a short pause, now and then a long one.
  function automatic int pick_gap();
    int roll;
    if (calm) begin
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 65) begin
      return 0;
    end else if (roll < 93) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(6, 24);
  endfunction

  // Offers one byte and returns at the edge on which it is accepted. The valid
  // stays high on return, so a following call with no gap keeps the stream
  // going without a bubble. The expected result is queued at acceptance.
  task automatic send_byte(input logic [7:0] b, input logic start, input logic typed,
                           input chbd_pkg::result_t want);
    int                gap;
    chbd_pkg::result_t predicted;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.in_byte       <= b;
    in_ch.message_start <= start;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    predicted = decode_byte(b, start);
    awaited_results.push_back(typed ? want : predicted);
  endtask

  // Stops offering bytes and waits until every owed result has come back,
  // then lets the pipeline settle.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Size limit writes only ever happen with the block empty.
  task automatic write_limit(input logic [chbd_pkg::LIMIT_W-1:0] value);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    size_limit = value;
  endtask

  task automatic report_mismatch(input string field, input logic [7:0] got,
                                 input logic [7:0] want);
    if (mismatches < 40) begin
      $display("[%0t] result %0d: %s is %0h, expected %0h", $realtime, results_seen,
               field, got, want);
    end
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Message construction for the random part.
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) begin
      return 8'("0") + 8'(nib);
    end
    return (($urandom_range(0, 1) != 0) ? 8'("A") : 8'("a")) + 8'(nib) - 8'd10;
  endfunction

  function automatic logic [7:0] any_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // Writes a size in hex, now and then with leading zeros.
  task automatic put_size(input logic [31:0] value);
    int n;
    int lead;
    n = 1;
    while (n < 8 && (value >> (4 * n)) != 0) n++;
    lead = ($urandom_range(0, 7) == 0) ? int'($urandom_range(1, 2)) : 0;
    repeat (lead) frame_q.push_back("0");
    for (int i = n - 1; i >= 0; i--) begin
      frame_q.push_back(hex_char(value[4*i +: 4]));
    end
  endtask

  // An optional extension: a semicolon and a few bytes that may well be hex
  // digits, which the decoder must not pick up.
  task automatic put_extension();
    logic [7:0] b;
    if ($urandom_range(0, 3) == 0) begin
      frame_q.push_back(";");
      repeat ($urandom_range(0, 3)) begin
        b = ($urandom_range(0, 1) != 0) ? hex_char(4'($urandom_range(0, 15))) : any_byte();
        if (b == chbd_pkg::CH_CR || b == chbd_pkg::CH_LF) begin
          b = "x";
        end
        frame_q.push_back(b);
      end
    end
  endtask

  task automatic put_crlf();
    frame_q.push_back(chbd_pkg::CH_CR);
    frame_q.push_back(chbd_pkg::CH_LF);
  endtask

  // Fills frame_q with one message. Most are well formed with random sizes,
  // extensions and data; some are corrupted or cut short, some carry a size
  // line far too long, and a few are plain noise.
  task automatic build_message(input logic [chbd_pkg::LIMIT_W-1:0] limit);
    int          kind;
    int          chunks;
    int          size;
    int          cap;
    int          sel;
    int          pos;
    longint      lim;
    logic [31:0] wide;
    frame_q.delete();
    lim  = longint'(limit);
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      repeat ($urandom_range(1, 10)) begin
        case ($urandom_range(0, 3))
          0:       frame_q.push_back(chbd_pkg::CH_CR);
          1:       frame_q.push_back(chbd_pkg::CH_LF);
          2:       frame_q.push_back(hex_char(4'($urandom_range(0, 15))));
          default: frame_q.push_back(any_byte());
        endcase
      end
    end else if (kind < 16) begin
      // Eight or nine digits: mostly oversize, and with nine the shift-add
      // usually overflows the counter.
      wide = $urandom();
      for (int i = 7; i >= 0; i--) begin
        frame_q.push_back(hex_char(wide[4*i +: 4]));
      end
      if ($urandom_range(0, 1) != 0) begin
        frame_q.push_back(hex_char(4'($urandom_range(0, 15))));
      end
      put_crlf();
      repeat ($urandom_range(0, 3)) frame_q.push_back(any_byte());
    end else begin
      chunks = (lim == 0) ? 0 : int'($urandom_range(0, 3));
      if (lim == 0 && $urandom_range(0, 3) == 0) begin
        chunks = 1;
      end
      repeat (chunks) begin
        sel = $urandom_range(0, 19);
        if (sel == 0 && lim < 64) begin
          size = int'(lim) + 1;
        end else if (sel == 1 && lim < 64) begin
          size = (lim == 0) ? 1 : int'(lim);
        end else begin
          cap = (sel < 4) ? 40 : 8;
          if (lim < cap) begin
            cap = int'(lim);
          end
          if (cap < 1) begin
            cap = 1;
          end
          size = $urandom_range(1, cap);
        end
        put_size(32'(size));
        put_extension();
        put_crlf();
        repeat (size) frame_q.push_back(any_byte());
        put_crlf();
      end
      put_size(32'd0);
      put_extension();
      put_crlf();
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 2)) frame_q.push_back(any_byte());
      end
      // Roughly one well-formed message in seven is damaged at a random spot.
      if (kind < 28) begin
        pos = $urandom_range(0, frame_q.size() - 1);
        case ($urandom_range(0, 3))
          0: frame_q[pos] = any_byte();
          1: frame_q[pos] = chbd_pkg::CH_CR;
          2: frame_q[pos] = chbd_pkg::CH_LF;
          default: begin
            frame_q = frame_q[0:pos];
          end
        endcase
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure and checking.
  // ---------------------------------------------------------------------------

  initial begin : result_sink
    int                stall;
    chbd_pkg::result_t got;
    chbd_pkg::result_t want;
    stall = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        got = '{out_ch.payload_byte, out_ch.payload_valid, out_ch.message_done,
                out_ch.format_error};
        if (awaited_results.size() == 0) begin
          report_mismatch("unexpected transaction", 8'(got), 8'h00);
        end else begin
          want = awaited_results.pop_front();
          if (got.payload_byte !== want.payload_byte) begin
            report_mismatch("payload_byte", got.payload_byte, want.payload_byte);
          end
          if (got.payload_valid !== want.payload_valid) begin
            report_mismatch("payload_valid", 8'(got.payload_valid), 8'(want.payload_valid));
          end
          if (got.message_done !== want.message_done) begin
            report_mismatch("message_done", 8'(got.message_done), 8'(want.message_done));
          end
          if (got.format_error !== want.format_error) begin
            report_mismatch("format_error", 8'(got.format_error), 8'(want.format_error));
          end
        end
        results_seen++;
      end
      // A long hold-off requested by the stimulus overrides the random gaps,
      // so the block's queue fills and it has to refuse input.
      if (hold_request > 0) begin
        stall = hold_request;
        hold_request = 0;
      end
      if (stall > 0) begin
        stall--;
        out_ch.ready <= 1'b0;
      end else begin
        stall = pick_gap();
        out_ch.ready <= (stall == 0);
        if (stall > 0) begin
          stall--;
        end
      end
    end
  end

  // Ends the run if nothing moves on either side for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("FAIL http_chunked_body_decoder");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus.
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    logic [chbd_pkg::LIMIT_W-1:0] settings [6];
    int                           sent;
    bit                           paused;
    rst_n               <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_wdata           <= '0;
    in_ch.valid         <= 1'b0;
    in_ch.in_byte       <= 8'h00;
    in_ch.message_start <= 1'b0;
    size_limit = 31'h7FFF_FFFF;
    clear_parser();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening, walked row by row.
    foreach (OPENING[i]) begin
      if (OPENING[i].kind == ROW_LIMIT) begin
        write_limit(OPENING[i].limit);
      end else begin
        send_byte(OPENING[i].data, OPENING[i].start, OPENING[i].typed, OPENING[i].want);
      end
    end

    // Random messages under a sequence of size limits, both extremes included.
    settings[0] = 31'h7FFF_FFFF;
    settings[1] = 31'd16;
    settings[2] = 31'($urandom_range(2, 4095));
    settings[3] = 31'd0;
    settings[4] = 31'd1;
    settings[5] = 31'h7FFF_FFFF;
    paused = 1'b0;
    foreach (settings[p]) begin
      write_limit(settings[p]);
      sent = 0;
      while (sent < BYTES_PER_SETTING) begin
        calm = ($urandom_range(0, 4) == 0);
        if (sent == 0 && (p == 1 || p == 4)) begin
          hold_request = 90;
        end
        // Once, in mid-setting, the sender waits for every result to come home.
        if (p == 2 && sent > 150 && !paused) begin
          drain_results();
          paused = 1'b1;
        end
        build_message(settings[p]);
        foreach (frame_q[i]) begin
          send_byte(frame_q[i],
                    (i == 0) ? ($urandom_range(0, 15) != 0) : ($urandom_range(0, 299) == 0),
                    1'b0, NOTHING);
        end
        sent += frame_q.size();
      end
    end

    calm = 1'b0;
    drain_results();
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("PASS http_chunked_body_decoder");
    end else begin
      $display("FAIL http_chunked_body_decoder");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/chbd_pkg.sv
src/chbd_if.sv
src/chbd_front.sv
src/chbd_queue.sv
src/chbd_back.sv
src/http_chunked_body_decoder.sv
tb/http_chunked_body_decoder_test.sv
